@@ sv/refcounted_slot_cache_macros.svh @@
// Assertion macros used by the slot cache sequencer (rsc_seq).
// Define NO_ASSERTIONS to compile the checks out.
`ifndef REFCOUNTED_SLOT_CACHE_MACROS_SVH
`define REFCOUNTED_SLOT_CACHE_MACROS_SVH

`ifndef NO_ASSERTIONS

// A property that must hold at every clock edge outside reset.
`define RSC_ASSERT(lbl, clk_s, rst_s, prop) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (prop)) \
    else $error("slot cache assertion failed");

// A condition in one cycle implies a consequence in the same cycle.
`define RSC_ASSERT_IMP(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
    else $error("slot cache implication failed");

// A condition in one cycle implies a consequence in the next cycle.
`define RSC_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
    else $error("slot cache next-cycle check failed");

`else

`define RSC_ASSERT(lbl, clk_s, rst_s, prop)
`define RSC_ASSERT_IMP(lbl, clk_s, rst_s, ante, cons)
`define RSC_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons)

`endif

`endif

@@ sv/rsc_pkg.sv @@
package rsc_pkg;

  localparam int ENTRIES    = 16;
  localparam int CNT_BITS   = 16;
  localparam int TAG_W      = 32;
  localparam int IDX_W      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int PTR_W      = $clog2(ENTRIES + 1);
  localparam int SLOT_W     = 4;
  localparam int STAT_W     = 3;
  localparam int OUT_DATA_W = 40;
  localparam int OUT_PAD_W  = OUT_DATA_W - (1 + SLOT_W + 1 + TAG_W);

  typedef logic [TAG_W-1:0]    tag_t;
  typedef logic [CNT_BITS-1:0] cnt_t;
  typedef logic [IDX_W-1:0]    idx_t;
  typedef logic [PTR_W-1:0]    ptr_t;

  localparam cnt_t CNT_MAX = '1;
  localparam cnt_t CNT_ONE = cnt_t'(1);

  typedef enum logic {
    CMD_GET = 1'b0,
    CMD_REL = 1'b1
  } cmd_t;

  typedef enum logic [STAT_W-1:0] {
    ST_HIT      = 3'd0,
    ST_FILL     = 3'd1,
    ST_REPL     = 3'd2,
    ST_FULL     = 3'd3,
    ST_REL_DONE = 3'd4,
    ST_REL_MISS = 3'd5
  } status_t;

  typedef struct packed {
    tag_t tag;
    cnt_t cnt;
  } entry_t;

  typedef struct packed {
    logic en;
    idx_t addr;
    tag_t tag;
    cnt_t cnt;
  } wr_t;

  typedef struct packed {
    status_t           status;
    logic              found;
    logic [SLOT_W-1:0] slot;
    logic              ev_valid;
    tag_t              ev_index;
  } rsp_t;

endpackage

@@ sv/rsc_store.sv @@
// Slot table memory: one write port, one read port with registered data.
module rsc_store (
  input  logic              clk,
  input  logic              rd_en,
  input  rsc_pkg::idx_t     rd_addr,
  output rsc_pkg::entry_t   rd_data,
  input  rsc_pkg::wr_t      wr
);

  rsc_pkg::entry_t mem [rsc_pkg::ENTRIES];
  rsc_pkg::entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= '{tag: wr.tag, cnt: wr.cnt};
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ sv/rsc_seq.sv @@
`include "refcounted_slot_cache_macros.svh"

// Request sequencer: scans the used slots through one tag comparator, then
// applies a single table update and forms the response.
module rsc_seq (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              req_valid,
  output logic              req_ready,
  input  rsc_pkg::cmd_t     req_cmd,
  input  rsc_pkg::tag_t     req_tag,
  output logic              rsp_valid,
  input  logic              rsp_ready,
  output rsc_pkg::rsp_t     rsp,
  output logic              rd_en,
  output rsc_pkg::idx_t     rd_addr,
  input  rsc_pkg::entry_t   rd_data,
  output rsc_pkg::wr_t      wr
);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_SCAN   = 4'b0010,
    S_DECIDE = 4'b0100,
    S_RESP   = 4'b1000
  } state_t;

  state_t              state_r, state_nxt;
  rsc_pkg::cmd_t       cmd_r, cmd_nxt;
  rsc_pkg::tag_t       key_r, key_nxt;
  rsc_pkg::ptr_t       used_r, used_nxt;
  rsc_pkg::ptr_t       ptr_r, ptr_nxt;
  logic                pend_r, pend_nxt;
  rsc_pkg::idx_t       pend_slot_r, pend_slot_nxt;
  logic                hit_r, hit_nxt;
  rsc_pkg::idx_t       hit_slot_r, hit_slot_nxt;
  rsc_pkg::cnt_t       hit_cnt_r, hit_cnt_nxt;
  logic                zero_r, zero_nxt;
  rsc_pkg::idx_t       zero_slot_r, zero_slot_nxt;
  rsc_pkg::tag_t       zero_tag_r, zero_tag_nxt;
  rsc_pkg::rsp_t       rsp_r, rsp_nxt;

  logic tag_eq;
  logic cnt_zero;
  logic is_match;
  logic is_zero;

  assign rd_en   = (state_r == S_SCAN) && (ptr_r != used_r);
  assign rd_addr = ptr_r[rsc_pkg::IDX_W-1:0];

  // The shared compare unit, fed one stored slot per cycle.
  assign tag_eq   = (rd_data.tag == key_r);
  assign cnt_zero = (rd_data.cnt == '0);
  assign is_match = pend_r && tag_eq && ((cmd_r == rsc_pkg::CMD_GET) || !cnt_zero);
  assign is_zero  = pend_r && cnt_zero && (cmd_r == rsc_pkg::CMD_GET);

  assign req_ready = (state_r == S_IDLE);
  assign rsp_valid = (state_r == S_RESP);
  assign rsp       = rsp_r;

  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    key_nxt       = key_r;
    used_nxt      = used_r;
    ptr_nxt       = ptr_r;
    pend_nxt      = rd_en;
    pend_slot_nxt = rd_addr;
    hit_nxt       = hit_r;
    hit_slot_nxt  = hit_slot_r;
    hit_cnt_nxt   = hit_cnt_r;
    zero_nxt      = zero_r;
    zero_slot_nxt = zero_slot_r;
    zero_tag_nxt  = zero_tag_r;
    rsp_nxt       = rsp_r;
    wr            = '0;

    case (state_r)
      S_IDLE: begin
        if (req_valid) begin
          cmd_nxt   = req_cmd;
          key_nxt   = req_tag;
          ptr_nxt   = '0;
          hit_nxt   = 1'b0;
          zero_nxt  = 1'b0;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (rd_en) begin
          ptr_nxt = ptr_r + 1'b1;
        end
        if (is_match && !hit_r) begin
          hit_nxt      = 1'b1;
          hit_slot_nxt = pend_slot_r;
          hit_cnt_nxt  = rd_data.cnt;
        end
        if (is_zero && !zero_r) begin
          zero_nxt      = 1'b1;
          zero_slot_nxt = pend_slot_r;
          zero_tag_nxt  = rd_data.tag;
        end
        if (!rd_en) begin
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        wr.tag  = key_r;
        rsp_nxt = '0;
        if (cmd_r == rsc_pkg::CMD_GET) begin
          if (hit_r) begin
            wr.en          = 1'b1;
            wr.addr        = hit_slot_r;
            wr.cnt         = (hit_cnt_r == rsc_pkg::CNT_MAX) ? hit_cnt_r : hit_cnt_r + 1'b1;
            rsp_nxt.status = rsc_pkg::ST_HIT;
            rsp_nxt.slot   = rsc_pkg::SLOT_W'(hit_slot_r);
          end else if (used_r != rsc_pkg::PTR_W'(rsc_pkg::ENTRIES)) begin
            wr.en          = 1'b1;
            wr.addr        = used_r[rsc_pkg::IDX_W-1:0];
            wr.cnt         = rsc_pkg::CNT_ONE;
            used_nxt       = used_r + 1'b1;
            rsp_nxt.status = rsc_pkg::ST_FILL;
            rsp_nxt.slot   = rsc_pkg::SLOT_W'(used_r[rsc_pkg::IDX_W-1:0]);
          end else if (zero_r) begin
            wr.en            = 1'b1;
            wr.addr          = zero_slot_r;
            wr.cnt           = rsc_pkg::CNT_ONE;
            rsp_nxt.status   = rsc_pkg::ST_REPL;
            rsp_nxt.slot     = rsc_pkg::SLOT_W'(zero_slot_r);
            rsp_nxt.ev_valid = 1'b1;
            rsp_nxt.ev_index = zero_tag_r;
          end else begin
            rsp_nxt.status = rsc_pkg::ST_FULL;
          end
        end else begin
          if (hit_r) begin
            wr.en          = 1'b1;
            wr.addr        = hit_slot_r;
            wr.cnt         = hit_cnt_r - 1'b1;
            rsp_nxt.status = rsc_pkg::ST_REL_DONE;
            rsp_nxt.found  = 1'b1;
          end else begin
            rsp_nxt.status = rsc_pkg::ST_REL_MISS;
          end
        end
        state_nxt = S_RESP;
      end
      S_RESP: begin
        if (rsp_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      used_r  <= '0;
      ptr_r   <= '0;
      pend_r  <= 1'b0;
      hit_r   <= 1'b0;
      zero_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      used_r  <= used_nxt;
      ptr_r   <= ptr_nxt;
      pend_r  <= pend_nxt;
      hit_r   <= hit_nxt;
      zero_r  <= zero_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r       <= cmd_nxt;
    key_r       <= key_nxt;
    pend_slot_r <= pend_slot_nxt;
    hit_slot_r  <= hit_slot_nxt;
    hit_cnt_r   <= hit_cnt_nxt;
    zero_slot_r <= zero_slot_nxt;
    zero_tag_r  <= zero_tag_nxt;
    rsp_r       <= rsp_nxt;
  end

  `RSC_ASSERT(a_used_bound, clk, rst_n, used_r <= rsc_pkg::PTR_W'(rsc_pkg::ENTRIES))
  `RSC_ASSERT_IMP(a_ptr_bound, clk, rst_n, state_r == S_SCAN, ptr_r <= used_r)
  `RSC_ASSERT_IMP(a_wr_decide, clk, rst_n, wr.en, state_r == S_DECIDE)
  `RSC_ASSERT_NEXT(a_rel_keeps_used, clk, rst_n, (state_r == S_DECIDE) && (cmd_r == rsc_pkg::CMD_REL), used_r == $past(used_r))

endmodule

@@ sv/refcounted_slot_cache.sv @@
// Reference-counted slot cache. The block keeps a fully associative table
// of 16 slots, each holding a 32-bit block index and a 16-bit reader count.
// A get request (in_tuser = 0) either hits and raises the slot's count
// (saturating), fills the next unused slot, or replaces the lowest slot whose
// count is zero and reports the index it evicted; with every slot busy it
// reports full and changes nothing. A release request (in_tuser = 1) lowers
// the count of the matching slot that has readers, or reports not found.
// Each request returns exactly one response. Requests are handled one at a
// time: the single tag comparator visits one stored slot per cycle through
// the table memory's registered read port, followed by an update step and a
// response step. A finished response waits in an output register, so the
// next request is accepted while it is still pending. The table needs no
// clearing after reset: only slots below the used count are ever read.
module refcounted_slot_cache (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] block_index
  input  logic        in_tuser,   // [0] command
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [0] release_found, [4:1] slot,
                                  // [5] evicted_valid, [37:6] evicted_index,
                                  // [39:38] zero
  output logic [2:0]  out_tuser   // [2:0] status
);

  logic              rsp_valid;
  logic              rsp_ready;
  rsc_pkg::rsp_t     rsp;
  logic              rd_en;
  rsc_pkg::idx_t     rd_addr;
  rsc_pkg::entry_t   rd_data;
  rsc_pkg::wr_t      wr;

  logic              out_valid_r, out_valid_nxt;
  rsc_pkg::rsp_t     out_rsp_r, out_rsp_nxt;

  rsc_store u_store (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr      (wr)
  );

  rsc_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (in_tvalid),
    .req_ready (in_tready),
    .req_cmd   (rsc_pkg::cmd_t'(in_tuser)),
    .req_tag   (in_tdata),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data),
    .wr        (wr)
  );

  // The output register takes a new response when it is empty or when its
  // current response leaves in the same cycle.
  assign rsp_ready = !out_valid_r || out_tready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_rsp_nxt   = out_rsp_r;
    if (rsp_valid && rsp_ready) begin
      out_valid_nxt = 1'b1;
      out_rsp_nxt   = rsp;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_rsp_r <= out_rsp_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_rsp_r.status;
  assign out_tdata  = {{rsc_pkg::OUT_PAD_W{1'b0}}, out_rsp_r.ev_index, out_rsp_r.ev_valid,
                       out_rsp_r.slot, out_rsp_r.found};

endmodule

@@ bench/refcounted_slot_cache_test.sv @@
`timescale 1ns / 100ps

import rsc_pkg::*;

// Tracks the slot table on the side of the bench. It predicts the response to
// each accepted request and compares each response that the block hands out.
class slot_cache_tracker;
  tag_t        held_block[ENTRIES];
  cnt_t        readers[ENTRIES];
  int          slots_filled;
  rsp_t        awaited_responses[$];
  int          errors;

  function new();
    slots_filled = 0;
    errors       = 0;
  endfunction

  function int outstanding();
    return awaited_responses.size();
  endfunction

  task report(string field, logic [31:0] got, logic [31:0] want);
    $display("mismatch on %s: got %0h, expected %0h", field, got, want);
    errors++;
  endtask

  // Works out the response to one accepted request and updates the table.
  function void note_request(cmd_t cmd, tag_t block);
    rsp_t resp;
    bit   done;
    int   i;
    resp        = '0;
    resp.status = ST_FULL;
    done        = 1'b0;
    if (cmd == CMD_GET) begin
      for (i = 0; i < slots_filled && !done; i++) begin
        if (held_block[i] == block) begin
          if (readers[i] != CNT_MAX) readers[i]++;
          resp.status = ST_HIT;
          resp.slot   = SLOT_W'(i);
          done        = 1'b1;
        end
      end
      if (!done && slots_filled < ENTRIES) begin
        held_block[slots_filled] = block;
        readers[slots_filled]    = CNT_ONE;
        resp.status              = ST_FILL;
        resp.slot                = SLOT_W'(slots_filled);
        slots_filled++;
        done = 1'b1;
      end
      for (i = 0; i < slots_filled && !done; i++) begin
        if (readers[i] == '0) begin
          resp.status   = ST_REPL;
          resp.slot     = SLOT_W'(i);
          resp.ev_valid = 1'b1;
          resp.ev_index = held_block[i];
          held_block[i] = block;
          readers[i]    = CNT_ONE;
          done          = 1'b1;
        end
      end
    end else begin
      resp.status = ST_REL_MISS;
      for (i = 0; i < slots_filled && !done; i++) begin
        if (held_block[i] == block && readers[i] != '0) begin
          readers[i]--;
          resp.status = ST_REL_DONE;
          resp.found  = 1'b1;
          done        = 1'b1;
        end
      end
    end
    awaited_responses.push_back(resp);
  endfunction

  task check_response(logic [39:0] data, logic [2:0] user);
    rsp_t want;
    if (awaited_responses.size() == 0) begin
      report("unexpected response", data[31:0], '0);
    end else begin
      want = awaited_responses.pop_front();
      if (user != want.status) report("status", user, want.status);
      if (data[0] != want.found) report("release_found", data[0], want.found);
      if (data[4:1] != want.slot) report("slot", data[4:1], want.slot);
      if (data[5] != want.ev_valid) report("evicted_valid", data[5], want.ev_valid);
      if (data[37:6] != want.ev_index) report("evicted_index", data[37:6], want.ev_index);
    end
  endtask
endclass

module refcounted_slot_cache_test;

  // Several times the slowest correct run, which sends under a thousand
  // requests, each at most a full table scan long, plus gaps and stalls.
  localparam int unsigned CYCLE_LIMIT = 200000;
  // Longest request turnaround: a full table scan, update and response.
  localparam int          TAIL_CYCLES = 30;
  localparam tag_t        PINNED_BLOCK = 32'h5A5A_C3C3;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] in_tdata;
  logic        in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [39:0] out_tdata;
  logic [2:0]  out_tuser;

  slot_cache_tracker tracker = new();

  // Idling switches; both sides idle in bursts while these are set.
  bit          sender_gaps;
  bit          receiver_stalls;
  int unsigned cycle_count;

  // Block indices that the random part draws from. Gets of fresh indices
  // from the noise stream are added here so that they can be released later
  // instead of pinning a slot for the rest of the run.
  tag_t        block_pool[$];

  refcounted_slot_cache i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always #5 clk = ~clk;

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Presents one request and holds it until the block takes it. The valid is
  // left high on return, so back-to-back requests never lower and raise it in
  // the same step; a gap before the next request lowers it instead.
  task send_request(cmd_t cmd, tag_t block);
    if (sender_gaps && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= block;
    do @(posedge clk); while (!in_tready);
    tracker.note_request(cmd, block);
  endtask

  // Holds the sender off until every response in flight has come back.
  task wait_for_quiet();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (tracker.outstanding() != 0);
  endtask

  // Mostly well-formed traffic on the pool of indices, with a share of noise
  // on arbitrary indices. The release share sets how crowded the table gets:
  // a low share drives it toward full, a high one frees slots for eviction.
  task run_mix(int requests, int release_pct);
    cmd_t cmd;
    tag_t block;
    repeat (requests) begin
      if ($urandom_range(0, 99) < 6) begin
        block = $urandom;
        cmd   = cmd_t'($urandom_range(0, 1));
        if (cmd == CMD_GET) block_pool.push_back(block);
      end else begin
        block = block_pool[$urandom_range(0, block_pool.size() - 1)];
        cmd   = ($urandom_range(0, 99) < release_pct) ? CMD_REL : CMD_GET;
      end
      send_request(cmd, block);
    end
  endtask

  // Response side: takes every response offered and hands it to the tracker,
  // with bursts of back-pressure while stalls are enabled.
  initial begin
    wait (rst_n === 1'b1);
    forever begin
      if (receiver_stalls && $urandom_range(0, 5) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      if (out_tvalid && out_tready) tracker.check_response(out_tdata, out_tuser);
    end
  end

  initial begin
    int k;
    cycle_count     = 0;
    sender_gaps     = 1'b0;
    receiver_stalls = 1'b0;
    rst_n      <= 1'b0;
    in_tvalid  <= 1'b0;
    in_tdata   <= '0;
    in_tuser   <= CMD_GET;
    out_tready <= 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // A short warm-up on one index: a fill and a few hits, then releases
    // bring the count back down to zero and one more release finds the slot
    // idle.
    send_request(CMD_GET, PINNED_BLOCK);
    repeat (3) send_request(CMD_GET, PINNED_BLOCK);
    repeat (4) send_request(CMD_REL, PINNED_BLOCK);
    send_request(CMD_REL, PINNED_BLOCK);
    wait_for_quiet();

    // Directed part. Slot 0 now holds an idle index. Release of an index the
    // table does not hold, fills, a hit, a release down to zero readers and a
    // release that matches only an idle slot.
    sender_gaps     = 1'b1;
    receiver_stalls = 1'b1;
    send_request(CMD_REL, 32'h0000_0000);
    send_request(CMD_GET, 32'h0000_0000);
    send_request(CMD_GET, 32'hFFFF_FFFF);
    send_request(CMD_GET, 32'h0000_0000);
    send_request(CMD_REL, 32'hFFFF_FFFF);
    send_request(CMD_REL, 32'hFFFF_FFFF);
    // Fill the remaining slots so that the table has no unused entry left.
    for (k = 0; k < 13; k++) send_request(CMD_GET, tag_t'(1) << k);
    // Two misses replace the idle slots, lowest first, and report what they
    // evicted; the third miss finds every slot busy and reports full.
    send_request(CMD_GET, 32'h8000_0000);
    send_request(CMD_GET, 32'h7FFF_FFFF);
    send_request(CMD_GET, 32'hDEAD_BEEF);
    send_request(CMD_REL, 32'hDEAD_BEEF);
    wait_for_quiet();

    // The pool holds everything the table may still hold, so no slot stays
    // pinned forever, plus a few fresh random indices.
    block_pool = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                   32'hDEAD_BEEF, PINNED_BLOCK};
    for (k = 0; k < 13; k++) block_pool.push_back(tag_t'(1) << k);
    repeat (12) block_pool.push_back($urandom);

    // Random part: a release-heavy phase with much eviction, then a
    // get-heavy phase that keeps the table full, each followed by a pause
    // until all responses are back.
    run_mix(300, 55);
    wait_for_quiet();
    run_mix(300, 40);
    wait_for_quiet();

    // Last stretch runs with both sides at full rate.
    sender_gaps     = 1'b0;
    receiver_stalls = 1'b0;
    run_mix(300, 50);
    in_tvalid <= 1'b0;

    while (tracker.outstanding() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (tracker.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+sv
sv/rsc_pkg.sv
sv/rsc_store.sv
sv/rsc_seq.sv
sv/refcounted_slot_cache.sv
bench/refcounted_slot_cache_test.sv
